// ----- src/sseu_pkg.sv -----
// Shared types and codes for the state-space Euler step unit.
`default_nettype none

package sseu_pkg;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // Register indexes (paddr[5:3])
  localparam logic [2:0] REG_A_ROW0  = 3'd0;
  localparam logic [2:0] REG_A_ROW1  = 3'd1;
  localparam logic [2:0] REG_B_COL   = 3'd2;
  localparam logic [2:0] REG_C_ROW   = 3'd3;
  localparam logic [2:0] REG_STEP_DT = 3'd4;
  localparam logic [2:0] REG_X_INIT  = 3'd5;

  // Multiplier operand pairs
  localparam logic [3:0] MUL_B0U   = 4'd0;
  localparam logic [3:0] MUL_A00X0 = 4'd1;
  localparam logic [3:0] MUL_A01X1 = 4'd2;
  localparam logic [3:0] MUL_B1U   = 4'd3;
  localparam logic [3:0] MUL_A10X0 = 4'd4;
  localparam logic [3:0] MUL_A11X1 = 4'd5;
  localparam logic [3:0] MUL_D0DT  = 4'd6;
  localparam logic [3:0] MUL_D1DT  = 4'd7;
  localparam logic [3:0] MUL_C0X0  = 4'd8;
  localparam logic [3:0] MUL_C1X1  = 4'd9;

  // Accumulator operations
  localparam logic [2:0] ACC_HOLD   = 3'd0;
  localparam logic [2:0] ACC_LOAD   = 3'd1;
  localparam logic [2:0] ACC_ADD    = 3'd2;
  localparam logic [2:0] ACC_LOADX0 = 3'd3;
  localparam logic [2:0] ACC_LOADX1 = 3'd4;

  typedef struct packed {
    logic [63:0] a_row0;
    logic [63:0] a_row1;
    logic [63:0] b_col;
    logic [63:0] c_row;
    logic [30:0] step_dt;
    logic [63:0] x_init;
  } cfg_t;

  typedef struct packed {
    logic       load_item;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic [2:0] acc_op;
    logic       wr_d0;
    logic       wr_d1;
    logic       wr_x0;
    logic       wr_x1;
    logic       wr_y;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ----- src/sseu_regs.sv -----
// Configuration register file behind the APB-style port.
`default_nettype none

module sseu_regs
  import sseu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (idx)
        REG_A_ROW0:  cfg.a_row0  <= pwdata;
        REG_A_ROW1:  cfg.a_row1  <= pwdata;
        REG_B_COL:   cfg.b_col   <= pwdata;
        REG_C_ROW:   cfg.c_row   <= pwdata;
        REG_STEP_DT: cfg.step_dt <= pwdata[30:0];
        REG_X_INIT:  cfg.x_init  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_A_ROW0:  prdata = cfg.a_row0;
      REG_A_ROW1:  prdata = cfg.a_row1;
      REG_B_COL:   prdata = cfg.b_col;
      REG_C_ROW:   prdata = cfg.c_row;
      REG_STEP_DT: prdata = {33'd0, cfg.step_dt};
      REG_X_INIT:  prdata = cfg.x_init;
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/sseu_dp.sv -----
// Datapath: shared multiplier, accumulator, state, derivative and output registers.
`default_nettype none

module sseu_dp
  import sseu_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int STATES    = 2
) (
  input  wire logic               clk,
  input  wire logic               restart,
  input  wire logic signed [31:0] sample_in,
  input  wire cfg_t               cfg,
  input  wire dp_cmd_t            cmd,
  output logic signed [31:0]      y_out
);

  localparam int  FS_W  = 64 - FRAC_BITS;
  localparam int  ACC_W = FS_W + 2;
  localparam bit  TWO   = (STATES >= 2);

  logic signed [31:0]      u;
  logic signed [31:0]      x0, x1;
  logic signed [31:0]      d0, d1;
  logic signed [63:0]      preg;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [31:0]      ma, mb;
  logic signed [FS_W-1:0]  fs;
  logic signed [ACC_W-1:0] fs_ext;
  logic signed [31:0]      acc_sat;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-32:0] hi;
    hi = v[ACC_W-1:31];
    if ((&hi) || !(|hi))
      return $signed(v[31:0]);
    else if (v[ACC_W-1])
      return 32'sh8000_0000;
    else
      return 32'sh7fff_ffff;
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MUL_B0U:   begin ma = $signed(cfg.b_col[31:0]);   mb = u;  end
      MUL_A00X0: begin ma = $signed(cfg.a_row0[31:0]);  mb = x0; end
      MUL_A01X1: begin ma = $signed(cfg.a_row0[63:32]); mb = x1; end
      MUL_B1U:   begin ma = $signed(cfg.b_col[63:32]);  mb = u;  end
      MUL_A10X0: begin ma = $signed(cfg.a_row1[31:0]);  mb = x0; end
      MUL_A11X1: begin ma = $signed(cfg.a_row1[63:32]); mb = x1; end
      MUL_D0DT:  begin ma = d0; mb = $signed({1'b0, cfg.step_dt}); end
      MUL_D1DT:  begin ma = d1; mb = $signed({1'b0, cfg.step_dt}); end
      MUL_C0X0:  begin ma = $signed(cfg.c_row[31:0]);   mb = x0; end
      MUL_C1X1:  begin ma = $signed(cfg.c_row[63:32]);  mb = x1; end
      default: ;
    endcase
    // single-state build: every term touching element 1 drops out
    if (!TWO && (cmd.mul_sel inside {MUL_A01X1, MUL_B1U, MUL_A10X0, MUL_A11X1,
                                     MUL_D1DT, MUL_C1X1})) begin
      ma = '0;
      mb = '0;
    end
  end

  // floor shift is an arithmetic right shift of the registered product
  assign fs      = preg[63:FRAC_BITS];
  assign fs_ext  = {{(ACC_W-FS_W){fs[FS_W-1]}}, fs};
  assign acc_sat = sat32(acc);

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD:   acc_next = fs_ext;
      ACC_ADD:    acc_next = acc + fs_ext;
      ACC_LOADX0: acc_next = {{(ACC_W-32){x0[31]}}, x0} + fs_ext;
      ACC_LOADX1: acc_next = {{(ACC_W-32){x1[31]}}, x1} + fs_ext;
      default:    acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      u <= sample_in;
    end
    if (cmd.mul_en) begin
      preg <= ma * mb;
    end
    acc <= acc_next;
    if (cmd.wr_d0) begin
      d0 <= acc_sat;
    end
    if (cmd.wr_d1) begin
      d1 <= acc_sat;
    end
    if (cmd.wr_y) begin
      y_out <= acc_sat;
    end
  end

  // state is control-visible: reset value is zero
  always_ff @(posedge clk) begin
    if (cmd.load_item && restart) begin
      x0 <= $signed(cfg.x_init[31:0]);
      if (TWO) begin
        x1 <= $signed(cfg.x_init[63:32]);
      end
    end else begin
      if (cmd.wr_x0) begin
        x0 <= acc_sat;
      end
      if (cmd.wr_x1 && TWO) begin
        x1 <= acc_sat;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/sseu_ctrl.sv -----
// Controller: handshakes and the fixed step sequence that drives the datapath.
`default_nettype none

module sseu_ctrl
  import sseu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dp_cmd_t   cmd,
  output logic      clear_state
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [3:0] STEP_LAST = 4'd13;

  logic       state, state_next;
  logic [3:0] step, step_next;
  logic       out_valid_next;
  logic       accept;
  logic       stall;
  logic       run;
  logic       finish;
  dp_cmd_t    prog;

  // Product issued in step k is accumulated in step k+1; saturated writes
  // read the accumulator before that step's update.
  function automatic dp_cmd_t program_step(input logic [3:0] s);
    dp_cmd_t c;
    c = '0;
    c.mul_sel = MUL_B0U;
    c.acc_op  = ACC_HOLD;
    case (s)
      4'd0:  begin c.mul_en = 1'b1; c.mul_sel = MUL_B0U; end
      4'd1:  begin c.mul_en = 1'b1; c.mul_sel = MUL_A00X0; c.acc_op = ACC_LOAD; end
      4'd2:  begin c.mul_en = 1'b1; c.mul_sel = MUL_A01X1; c.acc_op = ACC_ADD; end
      4'd3:  begin c.mul_en = 1'b1; c.mul_sel = MUL_B1U;   c.acc_op = ACC_ADD; end
      4'd4:  begin
        c.mul_en = 1'b1; c.mul_sel = MUL_A10X0; c.acc_op = ACC_LOAD; c.wr_d0 = 1'b1;
      end
      4'd5:  begin c.mul_en = 1'b1; c.mul_sel = MUL_A11X1; c.acc_op = ACC_ADD; end
      4'd6:  begin c.mul_en = 1'b1; c.mul_sel = MUL_D0DT;  c.acc_op = ACC_ADD; end
      4'd7:  begin c.acc_op = ACC_LOADX0; c.wr_d1 = 1'b1; end
      4'd8:  begin c.mul_en = 1'b1; c.mul_sel = MUL_D1DT; c.wr_x0 = 1'b1; end
      4'd9:  begin c.mul_en = 1'b1; c.mul_sel = MUL_C0X0; c.acc_op = ACC_LOADX1; end
      4'd10: begin c.acc_op = ACC_LOAD; c.wr_x1 = 1'b1; end
      4'd11: begin c.mul_en = 1'b1; c.mul_sel = MUL_C1X1; end
      4'd12: begin c.acc_op = ACC_ADD; end
      4'd13: begin c.wr_y = 1'b1; end
      default: ;
    endcase
    return c;
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  // last step waits while the previous result is still held
  assign stall    = (step == STEP_LAST) && out_valid && !out_ready;
  assign run      = (state == ST_RUN) && !stall;
  assign finish   = run && (step == STEP_LAST);
  assign prog     = program_step(step);

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = prog.mul_sel;
    cmd.acc_op    = ACC_HOLD;
    cmd.load_item = accept;
    if (run) begin
      cmd.mul_en = prog.mul_en;
      cmd.acc_op = prog.acc_op;
      cmd.wr_d0  = prog.wr_d0;
      cmd.wr_d1  = prog.wr_d1;
      cmd.wr_x0  = prog.wr_x0;
      cmd.wr_x1  = prog.wr_x1;
      cmd.wr_y   = prog.wr_y;
    end
  end

  assign clear_state = rst;

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
          step_next  = '0;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_next = ST_IDLE;
          step_next  = '0;
        end else if (run) begin
          step_next = step + 4'd1;
        end
      end
      default: begin
        state_next = ST_IDLE;
        step_next  = '0;
      end
    endcase
    out_valid_next = finish || (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready && (step == '0))
    else $error("request accepted but sequencer did not start at step zero");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_LAST)
    else $error("sequence step out of range");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (step == '0))
    else $error("idle with nonzero step");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && in_ready)
    else $error("finished sequence did not present a result");
`endif

endmodule

`default_nettype wire

// ----- src/state_space_euler_step_unit.sv -----
// Top level of the forward-Euler state-space step unit.
// Each accepted request (restart flag, control sample u) advances a two-state
// linear system by one forward-Euler step in signed fixed point with FRAC_BITS
// fraction bits (floor-shifted products, 32-bit saturation) and returns
// y = c*x of the new state. A restart reloads the state from x_init first;
// the state resets to zero. One shared 32x32 multiplier works through the ten
// products of a step, so the result lands in the output register at the end
// of the step sequence, and the unit takes no new request before that
// sequence has finished. The output register frees the input side,
// but the final step of the next item waits while an earlier result is
// still unread. Registers sit at byte address 8*i with 64-bit data; writes
// belong to idle periods only.
`default_nettype none

module state_space_euler_step_unit
  import sseu_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int STATES    = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               restart,
  input  wire logic signed [31:0] sample_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      y_out,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_cmd_t dp_cmd;
  logic    clear_state;

  sseu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sseu_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .clear_state (clear_state)
  );

  // reset clears the state vector by a forced reload from zero
  always_comb begin
    dp_cmd = cmd;
    if (clear_state) begin
      dp_cmd.load_item = 1'b1;
      dp_cmd.wr_x0     = 1'b0;
      dp_cmd.wr_x1     = 1'b0;
    end
  end

  sseu_dp #(
    .FRAC_BITS (FRAC_BITS),
    .STATES    (STATES)
  ) u_dp (
    .clk       (clk),
    .restart   (restart || clear_state),
    .sample_in (sample_in),
    .cfg       (clear_state ? cfg_t'('0) : cfg),
    .cmd       (dp_cmd),
    .y_out     (y_out)
  );

endmodule

`default_nettype wire
